// ----- hw/rtl/stw_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// stw_pkg
// Shared types, codes and constants of the stopwatch timer bank.
// ============================================================================
package stw_pkg;

	localparam int TIMER_COUNT_DEF = 4;

	localparam int US_W    = 48;
	localparam int TICKS_W = 42;

	// Action codes.
	localparam logic [2:0] ACT_RESET   = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_RESTART = 3'd2;
	localparam logic [2:0] ACT_STOP    = 3'd3;
	localparam logic [2:0] ACT_READ    = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_BAD_IDX = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	// Divider geometry: long division in 16-bit digits, remainder below 15625.
	localparam int DIV_NUM_W   = 64;
	localparam int DIV_DIGIT_W = 16;
	localparam int DIV_DIGITS  = DIV_NUM_W / DIV_DIGIT_W;
	localparam int DIV_REM_W   = 14;

	// ticks = us * hz / 1e6 reduces to us * 2^shift / 15625.
	localparam logic [DIV_REM_W-1:0] DIVISOR = 14'd15625;
	localparam int FAST_SHIFT = 7;
	localparam int SLOW_SHIFT = 3;

	// Reciprocal of the divisor, ceil(2^44 / 15625). It gives the exact digit
	// quotient for every partial dividend below 2^30.
	localparam int               DIV_RECIP_W     = 31;
	localparam int               DIV_RECIP_SHIFT = 44;
	localparam logic [30:0]      DIV_RECIP       = 31'd1125899907;

	typedef struct packed {
		logic [2:0]      action;
		logic [2:0]      timer_index;
		logic [US_W-1:0] now_us;
	} req_t;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic            running;
		logic [US_W-1:0] start_us;
		logic [US_W-1:0] acc_us;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- hw/rtl/stw_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// stw_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module stw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/stw_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// stw_div
// Divider by the constant 15625, one 16-bit quotient digit per multiply and remainder step.
// ============================================================================
module stw_div
	import stw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] dividend,
	output div_stat_t            stat,
	output logic [TICKS_W-1:0]   quotient
);

	localparam int CNT_W  = (DIV_DIGITS > 1) ? $clog2(DIV_DIGITS) : 1;
	localparam int CUR_W  = DIV_REM_W + DIV_DIGIT_W;
	localparam int PROD_W = CUR_W + DIV_RECIP_W;

	logic                   busy_q;
	logic                   done_q;
	logic                   phase_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIV_NUM_W-1:0]   num_q;
	logic [DIV_REM_W-1:0]   rem_q;
	logic [TICKS_W-1:0]     quo_q;
	logic [CUR_W-1:0]       cur_q;
	logic [DIV_DIGIT_W-1:0] qdig_q;

	logic [CUR_W-1:0]       cur;
	logic [PROD_W-1:0]      prod;
	logic [DIV_DIGIT_W-1:0] qdig;
	logic [CUR_W-1:0]       back;
	logic [CUR_W-1:0]       rem_full;

	// First half of a step: the digit quotient by reciprocal multiplication.
	assign cur  = {rem_q, num_q[DIV_NUM_W-1 -: DIV_DIGIT_W]};
	assign prod = {{DIV_RECIP_W{1'b0}}, cur} * {{CUR_W{1'b0}}, DIV_RECIP};
	assign qdig = prod[DIV_RECIP_SHIFT +: DIV_DIGIT_W];

	// Second half: the remainder that carries into the next digit.
	assign back     = {{DIV_REM_W{1'b0}}, qdig_q} * {{DIV_DIGIT_W{1'b0}}, DIVISOR};
	assign rem_full = cur_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (cnt_q == CNT_W'(DIV_DIGITS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				cur_q  <= cur;
				qdig_q <= qdig;
			end else begin
				num_q <= num_q << DIV_DIGIT_W;
				rem_q <= rem_full[DIV_REM_W-1:0];
				quo_q <= {quo_q[TICKS_W-1-DIV_DIGIT_W:0], qdig_q};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- hw/rtl/stopwatch_timer_bank.sv -----
`timescale 1ns / 1ps
// ============================================================================
// stopwatch_timer_bank
// Bank of stopwatch timers kept in a RAM, with tick scaling on read.
// ============================================================================
// Usage:
// Each request on the req channel (valid/ready) carries an action, a timer
// index and a microsecond time sample. Every request yields exactly one
// response on the rsp channel (valid/ready) with ticks and a status code.
// Requests are handled one at a time, and req_ready is high only while the
// block is idle. A request that does not read has its response loaded once
// S_EXEC has registered the entry read from the RAM and the running
// interval and S_UPD has updated the entry and written it back. The next
// request can be taken once the block is back in S_IDLE. A valid read adds
// the constant divider, which produces one 16-bit quotient digit per step,
// and its response is loaded when the divider reports its quotient.
// The response sits in an output register. When the receiver stalls, one
// more request is processed and its finished response is parked until the
// output register frees; req_ready stays low meanwhile. At reset all timers
// read as cleared through per-entry valid bits, so no clearing pass is
// needed, and the slow timer index (slow_q) returns to zero. The
// configuration register is written on any edge with cfg_wr_en.
// ============================================================================
module stopwatch_timer_bank
	import stw_pkg::*;
#(
	parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_HOLD = 3'd4;

	logic [2:0]             state_q;
	logic [2:0]             state_d;
	logic [1:0]             slow_q;
	logic [TIMER_COUNT-1:0] valid_q;
	req_t                   req_q;
	entry_t                 ent_s2;
	logic [US_W-1:0]        int_s2;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	rsp_t                   res_q;

	logic [IDX_W-1:0]       addr;
	logic                   idx_ok;
	logic [ENTRY_W-1:0]     ram_rdata;
	entry_t                 ent_rd;
	logic                   ram_we;
	entry_t                 ram_wdata;
	logic [US_W:0]          sum;
	logic [US_W-1:0]        elapsed;
	logic                   is_slow;
	logic                   div_start;
	logic [DIV_NUM_W-1:0]   dividend;
	div_stat_t              div_stat;
	logic [TICKS_W-1:0]     quotient;
	logic [1:0]             upd_status;
	logic                   upd_is_read;
	logic                   fin;
	rsp_t                   res_d;
	logic                   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign addr   = req_q.timer_index[IDX_W-1:0];
	assign idx_ok = ({1'b0, req_q.timer_index} < 4'(TIMER_COUNT));

	// The entry RAM is read at acceptance with the incoming index.
	stw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TIMER_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (ram_wdata),
		.re    (req_valid && req_ready),
		.raddr (req.timer_index[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// An entry never written since reset reads as a cleared timer.
	assign ent_rd = valid_q[addr] ? entry_t'(ram_rdata) : '0;

	// Elapsed time with the running interval added and saturated at 48 bits.
	assign sum     = {1'b0, ent_s2.acc_us} + {1'b0, int_s2};
	assign elapsed = !ent_s2.running ? ent_s2.acc_us
	               : (sum[US_W] ? {US_W{1'b1}} : sum[US_W-1:0]);
	assign is_slow = ({1'b0, slow_q} == req_q.timer_index);
	assign dividend = is_slow ? (DIV_NUM_W'(elapsed) << SLOW_SHIFT)
	                          : (DIV_NUM_W'(elapsed) << FAST_SHIFT);

	// Update of the selected entry, evaluated in the write-back cycle.
	always_comb begin
		ram_wdata   = ent_s2;
		ram_we      = 1'b0;
		upd_status  = ST_DONE;
		upd_is_read = 1'b0;
		priority if (req_q.action > ACT_READ) begin
			// Undefined actions leave everything alone and report done.
		end else if (!idx_ok) begin
			upd_status = ST_BAD_IDX;
		end else begin
			unique case (req_q.action)
				ACT_RESET: begin
					ram_wdata = '0;
					ram_we    = 1'b1;
				end
				ACT_START: begin
					if (ent_s2.running) begin
						upd_status = ST_IGNORED;
					end else begin
						ram_wdata.running  = 1'b1;
						ram_wdata.start_us = req_q.now_us;
						ram_we             = 1'b1;
					end
				end
				ACT_RESTART: begin
					ram_wdata.running  = 1'b1;
					ram_wdata.start_us = req_q.now_us;
					ram_wdata.acc_us   = '0;
					ram_we             = 1'b1;
				end
				ACT_STOP: begin
					if (!ent_s2.running) begin
						upd_status = ST_IGNORED;
					end else begin
						ram_wdata.running = 1'b0;
						ram_wdata.acc_us  = elapsed;
						ram_we            = 1'b1;
					end
				end
				ACT_READ: begin
					upd_is_read = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (state_q != S_UPD) begin
			ram_we      = 1'b0;
			upd_is_read = 1'b0;
		end
	end

	assign div_start = upd_is_read;

	stw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// A response is finished either in the write-back cycle of a request that
	// does not read, or when the divider reports its quotient.
	always_comb begin
		fin          = 1'b0;
		res_d.ticks  = '0;
		res_d.status = upd_status;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (upd_is_read) begin
					state_d = S_DIV;
				end else begin
					fin     = 1'b1;
					state_d = out_free ? S_IDLE : S_HOLD;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					fin          = 1'b1;
					res_d.ticks  = quotient;
					res_d.status = ST_DONE;
					state_d      = out_free ? S_IDLE : S_HOLD;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slow_q      <= '0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				slow_q <= cfg_wr_data;
			end
			if (ram_we) begin
				valid_q[addr] <= 1'b1;
			end
			if ((fin || state_q == S_HOLD) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == S_EXEC) begin
			ent_s2 <= ent_rd;
			int_s2 <= req_q.now_us - ent_rd.start_us;
		end
		if (fin) begin
			res_q <= res_d;
		end
		if (fin && out_free) begin
			rsp_q <= res_d;
		end else if (state_q == S_HOLD && out_free) begin
			rsp_q <= res_q;
		end
	end

	// The divider only runs while a read is in flight, never when idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !div_stat.busy)
		else $error("divider busy while accepting a request");

	// Write-back happens only in the update cycle and for a valid index.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_UPD && idx_ok))
		else $error("entry RAM written outside the update cycle");

	// A new response appears only after a finishing state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == S_UPD || $past(state_q) == S_DIV
		                      || $past(state_q) == S_HOLD))
		else $error("response raised without a finished request");

	// An accepted request always goes to the RAM read-data cycle next.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_EXEC))
		else $error("accepted request did not enter execution");

endmodule

// ----- tb/tb_stopwatch_timer_bank.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_stopwatch_timer_bank
// Self-checking regression for the stopwatch timer bank.
// ============================================================================
// A scoreboard class keeps its own copy of every timer and of the slow timer
// index. It turns each accepted request into the response the block should
// give. Each response the block hands over is compared field by field with
// the oldest one still waiting. A short directed pass covers the corner
// cases, and four random phases follow, each under a different slow timer
// setting. Both sides of the block idle at random. The receiver stalls once
// for a long stretch, and the sender drains the block before every register
// write.
// ============================================================================
module tb_stopwatch_timer_bank
	import stw_pkg::*;
();

	localparam int NUM_TIMERS  = TIMER_COUNT_DEF;
	localparam int IDLE_PCT    = 36;       // chance in a hundred of idling per cycle
	localparam int CYCLE_LIMIT = 200000;   // far above the slowest legal run
	localparam int SETTLE      = 4;        // idle edges after the last owed response
	localparam int TAIL_CYCLES = 40;       // covers a read through the divider
	localparam int PHASE_LEN   = 100;      // random requests per phase
	localparam int HOLD_AT     = 250;      // request count that starts the long stall
	localparam int HOLD_CYCLES = 300;
	localparam int STEADY_LEN  = 60;       // requests in the stretch with no idling

	// Action codes the block does not define. They must be answered as done
	// with zero ticks and must leave every timer alone.
	localparam logic [2:0] ACT_SPARE_A = 3'd5;
	localparam logic [2:0] ACT_SPARE_B = 3'd6;
	localparam logic [2:0] ACT_SPARE_C = 3'd7;

	localparam logic [US_W-1:0] US_MAX = {US_W{1'b1}};

	// ------------------------------------------------------------------------
	// Scoreboard: timer bank model plus the queue of responses still owed.
	// ------------------------------------------------------------------------
	class timer_scoreboard;
		bit              running [NUM_TIMERS];
		logic [US_W-1:0] start_us[NUM_TIMERS];
		logic [US_W-1:0] acc_us  [NUM_TIMERS];
		logic [1:0]      slow_idx;
		rsp_t            owed_q[$];
		int              errors;
		int              requests_seen;

		function new();
			for (int t = 0; t < NUM_TIMERS; t++) begin
				clear_timer(t);
			end
			slow_idx      = 2'd0;
			errors        = 0;
			requests_seen = 0;
		endfunction

		function void clear_timer(int t);
			running[t]  = 1'b0;
			start_us[t] = '0;
			acc_us[t]   = '0;
		endfunction

		// Accumulated time plus the running interval, which wraps with the
		// microsecond clock; the sum saturates at the top of 48 bits.
		function logic [US_W-1:0] timer_elapsed(int t, logic [US_W-1:0] now);
			logic [US_W-1:0] span;
			logic [63:0]     sum;
			if (!running[t]) begin
				return acc_us[t];
			end
			span = now - start_us[t];
			sum  = 64'(acc_us[t]) + 64'(span);
			return (sum > 64'(US_MAX)) ? US_MAX : sum[US_W-1:0];
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			int          t;
			logic [63:0] hz;
			logic [63:0] quot;
			e.ticks  = '0;
			e.status = ST_DONE;
			t = int'(r.timer_index);
			requests_seen++;
			if (r.action <= ACT_READ) begin
				if (t >= NUM_TIMERS) begin
					e.status = ST_BAD_IDX;
				end else if (r.action == ACT_RESET) begin
					clear_timer(t);
				end else if (r.action == ACT_START || r.action == ACT_RESTART) begin
					if (r.action == ACT_RESTART) begin
						clear_timer(t);
					end
					if (running[t]) begin
						e.status = ST_IGNORED;
					end else begin
						running[t]  = 1'b1;
						start_us[t] = r.now_us;
					end
				end else if (r.action == ACT_STOP) begin
					if (!running[t]) begin
						e.status = ST_IGNORED;
					end else begin
						acc_us[t]  = timer_elapsed(t, r.now_us);
						running[t] = 1'b0;
					end
				end else begin
					hz      = (t == int'(slow_idx)) ? 64'd512 : 64'd8192;
					quot    = (64'(timer_elapsed(t, r.now_us)) * hz) / 64'd1000000;
					e.ticks = quot[TICKS_W-1:0];
				end
			end
			owed_q.push_back(e);
		endfunction

		function void check_response(rsp_t r);
			rsp_t e;
			if (owed_q.size() == 0) begin
				$display("%0t: response with nothing owed: ticks %0d status %0d",
					$time, r.ticks, r.status);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			if (r.ticks !== e.ticks) begin
				$display("%0t: ticks mismatch: expected %0d, actual %0d",
					$time, e.ticks, r.ticks);
				errors++;
			end
			if (r.status !== e.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, e.status, r.status);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block under test and its stimulus signals.
	// ------------------------------------------------------------------------
	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_wr_data;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;

	timer_scoreboard sb = new();

	bit              steady = 1'b0;   // set while neither side may idle
	bit              held   = 1'b0;   // the long receiver stall has happened
	int              cycles = 0;
	logic [US_W-1:0] clock_us = '0;   // free-running time seen by the random phases

	stopwatch_timer_bank #(
		.TIMER_COUNT(NUM_TIMERS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog. A response that never arrives ends up here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("stopwatch_timer_bank regression: fail");
			$finish;
		end
	end

	// Monitor. Signals are sampled at the edge before the testbench drives new
	// values, so the scoreboard sees exactly what the block latched. A register
	// write goes into the model at the same edge the block takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				sb.slow_idx = cfg_wr_data;
			end
			if (req_valid && req_ready) begin
				sb.note_request(req);
			end
			if (rsp_valid && rsp_ready) begin
				sb.check_response(rsp);
			end
		end
	end

	// Receiver. It is ready about two thirds of the time. Once enough requests
	// have gone in, it holds off for a long stretch. The output register and
	// the one request the block buffers then fill, and req_ready has to drop
	// while the sender keeps offering.
	initial begin
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sb.requests_seen >= HOLD_AT) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) begin
					@(posedge clk);
				end
			end
			rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks.
	// ------------------------------------------------------------------------

	// Offers one request after a random gap and returns at the edge that takes
	// it. The caller may drive the next request at that very edge, so valid
	// stays high with no dip between back-to-back requests.
	task automatic issue_request(input logic [2:0] act, input logic [2:0] idx,
		input logic [US_W-1:0] now);
		req_t r;
		r.action      = act;
		r.timer_index = idx;
		r.now_us      = now;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
	endtask

	// Stops offering and waits until every owed response has come back. The
	// first edge lets the monitor record the request taken at the call edge.
	task automatic drain_block();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// The register may only change while the block is idle.
	task automatic write_slow_index(input logic [1:0] value);
		drain_block();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [US_W-1:0] random_us();
		logic [15:0] hi;
		logic [31:0] lo;
		hi = 16'($urandom_range(65535));
		lo = $urandom();
		return {hi, lo};
	endfunction

	// Mostly well-formed traffic on valid timers with a clock that moves
	// forward, so timers really run, stop and accumulate. About one request
	// in twelve is noise: any action code, any index and any time sample.
	task automatic run_random_phase(input int count, input bit with_steady);
		logic [2:0] act;
		logic [2:0] idx;
		int         pick;
		for (int n = 0; n < count; n++) begin
			steady = with_steady && (n < STEADY_LEN);
			if ($urandom_range(99) < 8) begin
				act = 3'($urandom_range(7));
				idx = 3'($urandom_range(7));
				issue_request(act, idx, random_us());
			end else begin
				idx  = 3'($urandom_range(NUM_TIMERS - 1));
				pick = $urandom_range(99);
				if (pick < 35) begin
					act = ACT_READ;
				end else if (pick < 55) begin
					act = ACT_START;
				end else if (pick < 75) begin
					act = ACT_STOP;
				end else if (pick < 88) begin
					act = ACT_RESTART;
				end else begin
					act = ACT_RESET;
				end
				pick = $urandom_range(99);
				if (pick < 85) begin
					clock_us = clock_us + US_W'($urandom_range(20000));
				end else if (pick < 95) begin
					// A big jump may carry the clock past its wrap.
					clock_us = clock_us + random_us();
				end else begin
					clock_us = random_us();
				end
				issue_request(act, idx, clock_us);
			end
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 2'd0;
		req_valid   <= 1'b0;
		req         <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass. The slow timer is still timer 0 from reset.
		issue_request(ACT_READ,    3'd0, '0);                 // a cleared timer reads zero
		issue_request(ACT_START,   3'd0, '0);
		issue_request(ACT_START,   3'd0, US_W'(100));         // start while running
		issue_request(ACT_READ,    3'd0, US_W'(1000000));     // one second of slow ticks
		issue_request(ACT_STOP,    3'd0, US_W'(2000000));
		issue_request(ACT_STOP,    3'd0, US_W'(2000001));     // stop while stopped
		issue_request(ACT_READ,    3'd0, US_MAX);             // stopped: time sample unused
		issue_request(ACT_START,   3'd1, US_MAX);
		issue_request(ACT_READ,    3'd1, US_W'(999999));      // interval across the clock wrap
		issue_request(ACT_RESTART, 3'd1, US_W'(5));           // restart of a running timer
		issue_request(ACT_STOP,    3'd1, US_W'(6));
		issue_request(ACT_START,   3'd2, '0);
		issue_request(ACT_STOP,    3'd2, US_MAX);             // accumulates the full range
		issue_request(ACT_START,   3'd2, US_W'(10));
		issue_request(ACT_READ,    3'd2, US_W'(5000));        // saturated elapsed time
		issue_request(ACT_STOP,    3'd2, US_W'(20));
		issue_request(ACT_RESET,   3'd2, '0);
		issue_request(ACT_READ,    3'd2, '0);
		issue_request(ACT_START,   3'd3, US_W'(12345));
		issue_request(ACT_READ,    3'd3, US_MAX);
		issue_request(ACT_READ,    3'd4, US_MAX);             // indexes past the bank
		issue_request(ACT_START,   3'd7, US_MAX);
		issue_request(ACT_STOP,    3'd5, '0);
		issue_request(ACT_RESET,   3'd6, '0);
		issue_request(ACT_SPARE_A, 3'd7, US_MAX);             // undefined action codes
		issue_request(ACT_SPARE_B, 3'd0, '0);
		issue_request(ACT_SPARE_C, 3'd3, US_MAX);

		// Random phases, each under its own slow timer. The drain before every
		// write is also the sender pause that empties the block completely.
		write_slow_index(2'd3);
		run_random_phase(PHASE_LEN, 1'b0);
		write_slow_index(2'd1);
		run_random_phase(PHASE_LEN, 1'b1);
		write_slow_index(2'd0);
		run_random_phase(PHASE_LEN, 1'b0);    // the long receiver stall falls here
		write_slow_index(2'd2);
		run_random_phase(PHASE_LEN, 1'b0);

		drain_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed_q.size() == 0) begin
			$display("stopwatch_timer_bank regression: pass");
		end else begin
			$display("stopwatch_timer_bank regression: fail");
		end
		$finish;
	end

endmodule
